// ===== hw/rtl/qec_pkg.sv =====
`default_nettype none

package qec_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned DELTA_W = 8;
    localparam int unsigned SHIFT_W = 2;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    // Largest detent shift honoured; a programmed 3 saturates to this
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 2'd2;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_READ   = 2'd1,
        REQ_WRITE  = 2'd2,
        REQ_RESYNC = 2'd3
    } req_t;

    typedef struct packed {
        req_t                    req;
        logic                    phase_a;
        logic                    phase_b;
        logic signed [POS_W-1:0] write_value;
    } item_t;

    // Gray phase pair to binary step index: A gives 3, B flips bit 0
    function automatic logic [1:0] gray_to_bin(input logic a, input logic b);
        gray_to_bin = {a, a ^ b};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qec_apb.sv =====
`default_nettype none

module qec_apb
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [qec_pkg::APB_AW-1:0]      paddr,
    input  wire logic [qec_pkg::APB_DW-1:0]      pwdata,
    output logic      [qec_pkg::APB_DW-1:0]      prdata,
    output logic                                 pready,
    output logic      [qec_pkg::SHIFT_W-1:0]     detent_shift
);

    logic [qec_pkg::SHIFT_W-1:0] detent_shift_reg;
    logic                        sel_shift;

    // Only the word at byte address zero holds a register
    assign sel_shift = (paddr[qec_pkg::APB_AW-1] == 1'b0);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detent_shift_reg <= '0;
        end
        else if (psel && penable && pwrite && sel_shift)
        begin
            detent_shift_reg <= pwdata[qec_pkg::SHIFT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_shift)
        begin
            prdata[qec_pkg::SHIFT_W-1:0] = detent_shift_reg;
        end
    end

    assign detent_shift = detent_shift_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/qec_core.sv =====
`default_nettype none

module qec_core
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  fire,
    input  wire qec_pkg::item_t                        item,
    input  wire logic        [qec_pkg::SHIFT_W-1:0]    detent_shift,
    output logic signed      [qec_pkg::POS_W-1:0]      read_position
);

    logic        [1:0]                    last_phase_reg;
    logic        [1:0]                    last_phase_next;
    logic        [qec_pkg::DELTA_W-1:0]   pending_delta_reg;
    logic        [qec_pkg::DELTA_W-1:0]   pending_delta_next;
    logic signed [qec_pkg::POS_W-1:0]     position_count_reg;
    logic signed [qec_pkg::POS_W-1:0]     position_count_next;

    logic        [1:0]                    now_phase;
    logic        [1:0]                    diff;
    logic        [qec_pkg::SHIFT_W-1:0]   shift_sat;
    logic signed [qec_pkg::POS_W-1:0]     delta_ext;
    logic signed [qec_pkg::POS_W-1:0]     step;
    logic        [qec_pkg::DELTA_W-1:0]   keep_mask;

    assign now_phase = qec_pkg::gray_to_bin(item.phase_a, item.phase_b);
    assign diff      = last_phase_reg - now_phase;
    assign shift_sat = (detent_shift > qec_pkg::SHIFT_MAX) ? qec_pkg::SHIFT_MAX : detent_shift;
    assign delta_ext = {{(qec_pkg::POS_W-qec_pkg::DELTA_W){pending_delta_reg[qec_pkg::DELTA_W-1]}},
                        pending_delta_reg};
    assign step      = delta_ext >>> shift_sat;
    assign keep_mask = ~({qec_pkg::DELTA_W{1'b1}} << shift_sat);

    always_comb
    begin
        last_phase_next     = last_phase_reg;
        pending_delta_next  = pending_delta_reg;
        position_count_next = position_count_reg;
        case (item.req)
            qec_pkg::REQ_TICK:
            begin
                // Single step only: an even difference is noise or a skipped state
                if (diff[0])
                begin
                    last_phase_next    = now_phase;
                    pending_delta_next = pending_delta_reg +
                                         (diff[1] ? 8'd1 : {qec_pkg::DELTA_W{1'b1}});
                end
            end
            qec_pkg::REQ_READ:
            begin
                pending_delta_next  = pending_delta_reg & keep_mask;
                position_count_next = position_count_reg + step;
            end
            qec_pkg::REQ_WRITE:
            begin
                position_count_next = item.write_value;
            end
            default:
            begin
                last_phase_next     = now_phase;
                pending_delta_next  = '0;
                position_count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg     <= '0;
            pending_delta_reg  <= '0;
            position_count_reg <= '0;
        end
        else if (fire)
        begin
            last_phase_reg     <= last_phase_next;
            pending_delta_reg  <= pending_delta_next;
            position_count_reg <= position_count_next;
        end
    end

    assign read_position = position_count_next;

endmodule

`default_nettype wire

// ===== hw/rtl/quadrature_encoder_counter_unit.sv =====
`default_nettype none

// Quadrature encoder counter with 4x decoding and detent scaling. Each
// transfer on the request channel is one of: a sample tick carrying the
// levels of phases A and B, a position read, a position write, or a resync
// that captures the phases and clears the count. Ticks move an 8-bit pending
// step count by one for each adjacent phase change; a read folds that count,
// shifted right by the detent shift (0, 1 or 2; 3 acts as 2), into a 32-bit
// wrapping position and returns the new position as the only kind of result.
// Requests pass through an input register and the update logic into an
// output register, so one request is taken every cycle unless a read
// stalls; a read's result is registered. Only a read stalls behind a
// result that is still waiting to be taken - ticks, writes and resyncs keep
// flowing past it. The detent shift sits at byte address 0 of the APB port
// and may be changed only while no request is in flight.

module quadrature_encoder_counter_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic        [1:0]                   req_type,
    input  wire logic                                phase_a,
    input  wire logic                                phase_b,
    input  wire logic signed [qec_pkg::POS_W-1:0]    write_value,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed      [qec_pkg::POS_W-1:0]    position,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [qec_pkg::APB_AW-1:0]   paddr,
    input  wire logic        [qec_pkg::APB_DW-1:0]   pwdata,
    output logic             [qec_pkg::APB_DW-1:0]   prdata,
    output logic                                     pready
);

    logic                                  in_valid_reg;
    qec_pkg::item_t                        item_reg;
    logic                                  out_valid_reg;
    logic signed [qec_pkg::POS_W-1:0]      position_reg;

    logic                                  item_is_read;
    logic                                  advance;
    logic                                  item_fire;
    logic                                  in_accept;
    logic        [qec_pkg::SHIFT_W-1:0]    detent_shift;
    logic signed [qec_pkg::POS_W-1:0]      read_position;

    // Register map and detent shift
    qec_apb u_apb
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .detent_shift (detent_shift)
    );

    // Only a read needs room in the output register
    assign item_is_read = (item_reg.req == qec_pkg::REQ_READ);
    assign advance      = !item_is_read || !out_valid_reg || !out_stall;
    assign item_fire    = in_valid_reg && advance;
    assign in_stall     = in_valid_reg && !advance;
    assign in_accept    = in_valid && !in_stall;

    // Input register: load on accept, drop once the item has been applied
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (item_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.req         <= qec_pkg::req_t'(req_type);
            item_reg.phase_a     <= phase_a;
            item_reg.phase_b     <= phase_b;
            item_reg.write_value <= write_value;
        end
    end

    // Decoder state and position arithmetic
    qec_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (item_fire),
        .item          (item_reg),
        .detent_shift  (detent_shift),
        .read_position (read_position)
    );

    // Output register: capture a read result, release it on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_fire && item_is_read)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire && item_is_read)
        begin
            position_reg <= read_position;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;

    // A request waits only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_is_read && out_valid_reg && out_stall))
        else $error("request stalled without a held result");

    // Every applied read leaves a result in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item_is_read) |=> out_valid_reg)
        else $error("read applied but no result registered");

    // A waiting request stays put until it is applied
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !item_fire) |=> (in_valid_reg && $stable(item_reg)))
        else $error("waiting request lost or altered");

    // A result held under stall is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(position_reg)))
        else $error("held result overwritten");

endmodule

`default_nettype wire
